### hdl/bmp_stream_decoder_macros.svh
// Assertion macros for the BMP stream decoder.
`ifndef BMP_STREAM_DECODER_MACROS_SVH
`define BMP_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define BMP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BMP_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMP_ASSERT(label, clk, rst, prop, msg)
`define BMP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### hdl/bmp_pkg.sv
// Shared types and constants for the BMP stream decoder.
package bmp_pkg;
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int HdrLen    = 54;
  localparam logic [15:0] SigBm = 16'h4D42;
  localparam logic [31:0] CompRgb = 32'd0;
  localparam logic [31:0] CompBitfields = 32'd3;
  localparam logic [8:0]  PalMax = 9'd256;

  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_ZERO   = 3'd1;
  localparam logic [2:0] ERR_SIG    = 3'd2;
  localparam logic [2:0] ERR_PLANES = 3'd3;
  localparam logic [2:0] ERR_DEPTH  = 3'd4;
  localparam logic [2:0] ERR_COMP   = 3'd5;
  localparam logic [2:0] ERR_RANGE  = 3'd6;

  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_PAL  = 2'd1;
  localparam logic [1:0] FMT_RGB  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } bmp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  palette_index;
    logic [1:0]  format;
    logic        last;
  } bmp_out_t;
endpackage

### hdl/bmp_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface bmp_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/bmp_front.sv
// Front end: byte counting, header capture and header check.
module bmp_front (
  input  logic clk,
  input  logic rst,
  bmp_stream_if.sink in,
  output logic q_valid,
  input  logic q_ready,
  output logic [7:0] q_byte,
  output logic q_sof,
  output logic q_hdr_done,
  output logic [2:0] q_err,
  output logic [31:0] q_idx,
  output logic [31:0] hw, hh, hoffs, hinfo, hcols,
  output logic [15:0] hbpp
);
  import bmp_pkg::*;
  logic [31:0] cnt;
  logic [7:0] hdr [HdrLen];
  logic [31:0] idx;
  logic fire;
  assign in.ready = q_ready;
  assign fire = in.valid && q_ready;
  assign idx = in.data.start_of_file ? 32'd0 : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= (idx == 32'hFFFF_FFFF) ? idx : idx + 32'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (fire && idx < 32'(HdrLen)) hdr[idx[5:0]] <= in.data.byte_value;
  end

  // check runs on byte 53 from stored bytes 0..52; the last header byte is not needed
  logic [31:0] w, h, comp, cols, info, offs;
  logic [15:0] bpp, planes, sig;
  logic [32:0] pal_start, pal_end;
  logic [2:0] err;
  assign w = {hdr[21], hdr[20], hdr[19], hdr[18]};
  assign h = {hdr[25], hdr[24], hdr[23], hdr[22]};
  assign comp = {hdr[33], hdr[32], hdr[31], hdr[30]};
  assign info = {hdr[17], hdr[16], hdr[15], hdr[14]};
  assign offs = {hdr[13], hdr[12], hdr[11], hdr[10]};
  assign cols = {hdr[49], hdr[48], hdr[47], hdr[46]};
  assign bpp = {hdr[29], hdr[28]};
  assign planes = {hdr[27], hdr[26]};
  assign sig = {hdr[1], hdr[0]};
  assign hw = w;
  assign hh = h;
  assign hoffs = offs;
  assign hinfo = info;
  assign hcols = cols;
  assign hbpp = bpp;

  always_comb begin
    pal_start = 33'd14 + {1'b0, info};
    pal_end = pal_start + {cols[30:0], 2'b00};
    if (cols == 32'd0) pal_end = pal_start + 33'd1024;
    if (w == 0 || h == 0) err = ERR_ZERO;
    else if (sig != SigBm) err = ERR_SIG;
    else if (planes != 16'd1) err = ERR_PLANES;
    else if (bpp != 16'd8 && bpp != 16'd24 && bpp != 16'd32) err = ERR_DEPTH;
    else if (comp != CompRgb && comp != CompBitfields) err = ERR_COMP;
    else if (w > 32'(MaxWidth) || h > 32'(MaxHeight)) err = ERR_RANGE;
    else if (bpp == 16'd8) begin
      if (cols > 32'(PalMax)) err = ERR_RANGE;
      else if (pal_start < 33'(HdrLen)) err = ERR_RANGE;
      else if ({1'b0, offs} < pal_end) err = ERR_RANGE;
      else err = ERR_NONE;
    end else if (offs < 32'(HdrLen)) err = ERR_RANGE;
    else err = ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_ready) begin
      q_valid <= in.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (q_ready) begin
      q_byte <= in.data.byte_value;
      q_sof <= in.data.start_of_file;
      q_hdr_done <= (idx == 32'(HdrLen - 1));
      q_err <= err;
      q_idx <= idx;
    end
  end
endmodule

### hdl/bmp_back.sv
// Back end: palette and pixel sequencing with output register.
module bmp_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic [7:0] q_byte,
  input  logic q_sof,
  input  logic q_hdr_done,
  input  logic [2:0] q_err,
  input  logic [31:0] q_idx,
  input  logic [31:0] hw, hh, hoffs, hinfo, hcols,
  input  logic [15:0] hbpp,
  bmp_stream_if.source out
);
  import bmp_pkg::*;
  localparam logic [2:0] PH_HEADER = 3'd0, PH_SKIP_PAL = 3'd1, PH_PALETTE = 3'd2,
                         PH_SKIP_PIX = 3'd3, PH_PIXELS = 3'd4, PH_DONE = 3'd5;
  logic [2:0] phase;
  logic [12:0] width, height, col, row;
  logic [5:0] bpp;
  logic [31:0] offs;
  logic [32:0] skip;
  logic [8:0] ncols, ent;
  logic grey;
  logic [1:0] big, pad, rpad;
  logic [7:0] h0, h1, h2;
  logic fire, err_beat;
  assign q_ready = !out.valid || out.ready;
  assign fire = q_valid && q_ready;
  assign err_beat = out.valid && out.data.kind == KIND_ERROR;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; grey <= 1'b1; ent <= '0; big <= '0; col <= '0; row <= '0;
      pad <= '0; skip <= '0; width <= '0; height <= '0; bpp <= '0; ncols <= '0;
      offs <= '0; rpad <= '0;
      out.valid <= 1'b0;
    end else if (fire) begin
      logic [2:0] p; logic [8:0] e; logic [1:0] g; logic [1:0] gl;
      logic emit; bmp_out_t o;
      p = q_sof ? PH_HEADER : phase;
      e = q_sof ? 9'd0 : ent;
      g = q_sof ? 2'd0 : big;
      emit = 1'b0;
      o = '0;
      // position of the last byte of a pixel
      gl = bpp[5] ? 2'd3 : (bpp[4] ? 2'd2 : 2'd0);
      if (q_sof) begin
        grey <= 1'b1; col <= '0; row <= '0; pad <= '0;
      end
      unique case (p)
        PH_HEADER: begin
          if (q_hdr_done) begin
            if (q_err != ERR_NONE) begin
              p = PH_DONE; emit = 1'b1; o.kind = KIND_ERROR; o.error_code = q_err;
            end else begin
              width <= hw[12:0]; height <= hh[12:0]; bpp <= hbpp[5:0]; offs <= hoffs;
              rpad <= 2'(3'd4 - 3'(hw[1:0] * hbpp[4:3])) ;
              if (hbpp == 16'd8) begin
                ncols <= (hcols == 0) ? PalMax : hcols[8:0];
                skip <= 33'd14 + {1'b0, hinfo}; p = PH_SKIP_PAL;
              end else begin
                skip <= {1'b0, hoffs}; p = PH_SKIP_PIX;
              end
            end
          end
        end
        PH_SKIP_PAL, PH_PALETTE: begin
          if (p == PH_PALETTE || {1'b0, q_idx} >= skip) begin
            p = PH_PALETTE;
            unique case (g)
              2'd0: h0 <= q_byte;
              2'd1: h1 <= q_byte;
              2'd2: h2 <= q_byte;
              default: begin
                emit = 1'b1;
                if (ncols == PalMax && (h0 != h1 || h1 != h2 || {1'b0, h0} != e))
                  grey <= 1'b0;
                o.kind = KIND_PALETTE; o.red = h2; o.green = h1; o.blue = h0;
                o.palette_index = e[7:0]; o.format = FMT_PAL;
                e = e + 9'd1;
                if (e >= ncols) begin p = PH_SKIP_PIX; skip <= {1'b0, offs}; end
              end
            endcase
            g = g + 2'd1;
          end
        end
        PH_SKIP_PIX, PH_PIXELS: begin
          if (p == PH_PIXELS || {1'b0, q_idx} >= skip) begin
            p = PH_PIXELS;
            if (pad != 0) pad <= pad - 2'd1;
            else if (g != gl) begin
              if (g == 2'd0) h0 <= q_byte;
              else if (g == 2'd1) h1 <= q_byte;
              else h2 <= q_byte;
              g = g + 2'd1;
            end else begin
              g = 2'd0; emit = 1'b1;
              o.kind = KIND_PIXEL; o.pixel_x = col[11:0];
              o.pixel_y = 12'(height - 13'd1 - row);
              o.red = q_byte;
              if (bpp == 6'd8) begin
                o.green = q_byte; o.blue = q_byte; o.palette_index = q_byte;
                o.format = grey ? FMT_GREY : FMT_PAL;
              end else if (bpp == 6'd24) begin
                o.green = h1; o.blue = h0; o.format = FMT_RGB;
              end else begin
                o.green = h2; o.blue = h1; o.format = FMT_RGB;
              end
              o.last = (row == height - 13'd1) && (col == width - 13'd1);
              if (col + 13'd1 >= width) begin
                col <= '0; row <= row + 13'd1;
                if (row + 13'd1 >= height) p = PH_DONE;
                else pad <= rpad;
              end else col <= col + 13'd1;
            end
          end
        end
        default: ;
      endcase
      phase <= p; ent <= e; big <= g;
      out.valid <= emit;
      if (emit) out.data <= o;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

`include "bmp_stream_decoder_macros.svh"
  `BMP_ASSERT(a_no_overrun, clk, rst, (out.valid && !out.ready) |=> out.valid, "lost beat")
  `BMP_ASSERT(a_phase_ok, clk, rst, phase <= PH_DONE, "bad phase")
  `BMP_ASSERT(a_err_kind, clk, rst, err_beat |-> out.data.error_code != ERR_NONE, "error without code")
endmodule

### hdl/bmp_stream_decoder.sv
// BMP stream decoder top level.
// Takes one file byte per cycle and gives at most one result per byte; the front stage
// registers each byte with its header check, the back stage sequences palette and pixels
// and holds the result in an output register, so a byte is taken each cycle the output
// is free. A result passes the front register and then the output register.
module bmp_stream_decoder (
  input logic clk,
  input logic rst,
  bmp_stream_if.sink in,
  bmp_stream_if.source out
);
  import bmp_pkg::*;
  logic q_valid, q_ready, q_sof, q_hdr_done;
  logic [7:0] q_byte;
  logic [2:0] q_err;
  logic [31:0] q_idx;
  logic [31:0] hw, hh, hoffs, hinfo, hcols;
  logic [15:0] hbpp;

  bmp_front u_front (.clk, .rst, .in, .q_valid, .q_ready, .q_byte, .q_sof,
                     .q_hdr_done, .q_err, .q_idx, .hw, .hh, .hoffs, .hinfo, .hcols, .hbpp);
  bmp_back u_back (.clk, .rst, .q_valid, .q_ready, .q_byte, .q_sof, .q_hdr_done,
                   .q_err, .q_idx, .hw, .hh, .hoffs, .hinfo, .hcols, .hbpp, .out);
endmodule

### tb/sv/bmp_stream_decoder_test.sv
// Self-checking testbench for the BMP stream decoder: byte-stream files in, decoded beats checked.
`timescale 1ns / 100ps
module bmp_stream_decoder_test;
  import bmp_pkg::*;

  typedef enum int {PH_HDR, PH_SKIP_PAL, PH_PAL, PH_SKIP_PIX, PH_PIX, PH_DONE} phase_t;
  localparam int PAL_RAMP = 0, PAL_RANDOM = 1, PAL_BROKEN_RAMP = 2;

  logic clk = 1'b0;
  logic rst;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bmp_stream_if #(.T(bmp_in_t)) in_if (clk);
  bmp_stream_if #(.T(bmp_out_t)) out_if (clk);

  bmp_stream_decoder dut (.clk(clk), .rst(rst), .in(in_if), .out(out_if));

  // decoder shadow state
  phase_t      ph;
  logic [31:0] byte_count, img_w, img_h, bpp, pix_ofs, info_size, ncolours;
  logic [31:0] entry_cnt, col, row, pad_left, grp, grp_len, row_pad;
  logic [63:0] skip_to;
  logic [7:0]  hdr [54];
  logic [7:0]  held [4];
  bit          grey_ramp;

  bmp_out_t expected_results[$];
  int  fail_count, beats_checked, bytes_sent, files_sent;
  int  n_pixels, n_entries, n_errors;
  int  src_idle_pct, sink_idle_pct, hold_left;

  function automatic void clear_decoder();
    ph = PH_HDR;
    byte_count = 0; img_w = 0; img_h = 0; bpp = 0; pix_ofs = 0; info_size = 0;
    ncolours = 0; entry_cnt = 0; col = 0; row = 0; pad_left = 0; grp = 0;
    grp_len = 0; row_pad = 0; skip_to = 0; grey_ramp = 1'b1;
    foreach (hdr[i]) hdr[i] = 8'h00;
    foreach (held[i]) held[i] = 8'h00;
  endfunction

  function automatic logic [31:0] le_word(int pos, int n);
    logic [31:0] v = 0;
    for (int k = n - 1; k >= 0; k--) v = (v << 8) | hdr[pos + k];
    return v;
  endfunction

  function automatic logic [2:0] header_verdict();
    logic [31:0] w = le_word(18, 4), h = le_word(22, 4);
    logic [31:0] comp = le_word(30, 4), raw_cols = le_word(46, 4);
    logic [31:0] depth = le_word(28, 2);
    logic [63:0] pal_start, pal_end;
    if (w == 0 || h == 0) return ERR_ZERO;
    if (le_word(0, 2) != SigBm) return ERR_SIG;
    if (le_word(26, 2) != 1) return ERR_PLANES;
    if (depth != 8 && depth != 24 && depth != 32) return ERR_DEPTH;
    if (comp != CompRgb && comp != CompBitfields) return ERR_COMP;
    if (w > MaxWidth || h > MaxHeight) return ERR_RANGE;
    img_w = w; img_h = h; bpp = depth;
    pix_ofs = le_word(10, 4); info_size = le_word(14, 4);
    grp_len = depth / 8;
    row_pad = (4 - ((w * grp_len) & 3)) & 3;
    if (depth == 8) begin
      if (raw_cols > 256) return ERR_RANGE;
      ncolours = (raw_cols == 0) ? 256 : raw_cols;
      pal_start = {32'b0, info_size} + 14;
      if (pal_start < HdrLen) return ERR_RANGE;
      pal_end = pal_start + 4 * {32'b0, ncolours};
      if ({32'b0, pix_ofs} < pal_end) return ERR_RANGE;
      skip_to = pal_start;
      ph = PH_SKIP_PAL;
    end else begin
      if (pix_ofs < HdrLen) return ERR_RANGE;
      skip_to = {32'b0, pix_ofs};
      ph = PH_SKIP_PIX;
    end
    return ERR_NONE;
  endfunction

  // Advance the shadow decoder by one byte; got is set when a beat is due.
  function automatic void decode_byte(input logic [7:0] b, input bit sof,
                                      output bit got, output bmp_out_t r);
    logic [31:0] idx;
    logic [2:0]  err;
    got = 1'b0;
    r = '0;
    if (sof) clear_decoder();
    idx = byte_count;
    if (byte_count != 32'hFFFF_FFFF) byte_count++;
    if (ph == PH_HDR) begin
      if (idx < HdrLen) hdr[idx] = b;
      if (idx == HdrLen - 1) begin
        err = header_verdict();
        if (err != ERR_NONE) begin
          ph = PH_DONE;
          r.kind = KIND_ERROR;
          r.error_code = err;
          got = 1'b1;
        end
      end
      return;
    end
    if (ph == PH_SKIP_PAL) begin
      if ({32'b0, idx} < skip_to) return;
      ph = PH_PAL;
    end
    if (ph == PH_PAL) begin
      held[grp & 3] = b;
      grp++;
      if (grp < 4) return;
      grp = 0;
      if (ncolours == 256 && (held[0] != held[1] || held[1] != held[2] ||
                              {24'b0, held[0]} != entry_cnt))
        grey_ramp = 1'b0;
      r.kind = KIND_PALETTE;
      r.red = held[2]; r.green = held[1]; r.blue = held[0];
      r.palette_index = entry_cnt[7:0];
      r.format = FMT_PAL;
      got = 1'b1;
      entry_cnt++;
      if (entry_cnt >= ncolours) begin
        ph = PH_SKIP_PIX;
        skip_to = {32'b0, pix_ofs};
      end
      return;
    end
    if (ph == PH_SKIP_PIX) begin
      if ({32'b0, idx} < skip_to) return;
      ph = PH_PIX;
    end
    if (ph == PH_PIX) begin
      if (pad_left > 0) begin
        pad_left--;
        return;
      end
      held[grp & 3] = b;
      grp++;
      if (grp < grp_len) return;
      grp = 0;
      r.kind = KIND_PIXEL;
      r.pixel_x = col[11:0];
      r.pixel_y = 12'(img_h - 1 - row);
      r.red = b;
      if (bpp == 8) begin
        r.green = b; r.blue = b; r.palette_index = b;
        r.format = grey_ramp ? FMT_GREY : FMT_PAL;
      end else if (bpp == 24) begin
        r.green = held[1]; r.blue = held[0]; r.format = FMT_RGB;
      end else begin
        r.green = held[2]; r.blue = held[1]; r.format = FMT_RGB;
      end
      r.last = (row == img_h - 1 && col == img_w - 1);
      got = 1'b1;
      col++;
      if (col >= img_w) begin
        col = 0;
        row++;
        if (row >= img_h) ph = PH_DONE;
        else pad_left = row_pad;
      end
    end
  endfunction

  function automatic int pick_gap(int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 6);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit sof);
    int  gap = pick_gap(src_idle_pct);
    bit  taken, got;
    bmp_out_t r;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{byte_value: b, start_of_file: sof};
    do begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end while (!taken);
    decode_byte(b, sof, got, r);
    if (got) expected_results.push_back(r);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void put_le(ref logic [7:0] a [54], input int pos,
                                 input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) a[pos + k] = v[8 * k +: 8];
  endfunction

  // Build and stream one file; cut limits the byte count (negative: whole file).
  task automatic send_file(input logic [15:0] sig, planes, depth, input logic [31:0] comp,
                           input logic [31:0] w, h, cols, isz, ofs, input int pal_kind,
                           input bit first_sof = 1'b1, input int cut = -1,
                           input int mutate = 0);
    logic [7:0] a [54];
    logic [7:0] fb[$];
    int n, glen, pad, broken;
    foreach (a[i]) a[i] = 8'($urandom);
    put_le(a, 0, sig, 2);
    put_le(a, 10, ofs, 4);
    put_le(a, 14, isz, 4);
    put_le(a, 18, w, 4);
    put_le(a, 22, h, 4);
    put_le(a, 26, planes, 2);
    put_le(a, 28, depth, 2);
    put_le(a, 30, comp, 4);
    put_le(a, 46, cols, 4);
    foreach (a[i]) fb.push_back(a[i]);
    glen = (depth == 8 || depth == 24 || depth == 32) ? depth / 8 : 1;
    if (w <= MaxWidth && h <= MaxHeight && cols <= 256 && isz < 1024 && ofs < 4096) begin
      if (depth == 8) begin
        n = (cols == 0) ? 256 : cols;
        broken = $urandom_range(n - 1);
        while (fb.size() < 14 + isz) fb.push_back(8'($urandom));
        for (int e = 0; e < n; e++) begin
          logic [7:0] g = (pal_kind == PAL_RAMP || (pal_kind == PAL_BROKEN_RAMP && e != broken))
                          ? 8'(e) : 8'($urandom);
          fb.push_back(pal_kind == PAL_RANDOM ? 8'($urandom) : g);
          fb.push_back(pal_kind == PAL_RANDOM ? 8'($urandom) : g);
          fb.push_back(g);
          fb.push_back(8'($urandom));
        end
      end
      while (fb.size() < ofs) fb.push_back(8'($urandom));
      pad = (4 - ((w * glen) & 3)) & 3;
      for (int y = 0; y < h; y++)
        repeat (w * glen + pad) fb.push_back(8'($urandom));
      repeat ($urandom_range(3)) fb.push_back(8'($urandom));
    end
    repeat (mutate) fb[$urandom_range(HdrLen - 1)] = 8'($urandom);
    if (cut >= 0 && cut < fb.size()) fb = fb[0:cut - 1];
    foreach (fb[i]) send_byte(fb[i], (i == 0) && first_sof);
    files_sent++;
  endtask

  task automatic test_header_errors();
    src_idle_pct = 20; sink_idle_pct = 20;
    // no start mark on the very first file after reset
    send_file(SigBm, 1, 24, CompRgb, 2, 2, 0, 40, 54, PAL_RANDOM, 1'b0);
    send_file(SigBm, 1, 24, CompRgb, 0, 2, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 8, CompRgb, 3, 0, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(16'h4142, 1, 24, CompRgb, 2, 2, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 2, 24, CompRgb, 2, 2, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 16, CompRgb, 2, 2, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 24, 32'd1, 2, 2, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 24, CompRgb, 4097, 1, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    // negative height reads as oversize
    send_file(SigBm, 1, 32, CompRgb, 1, 32'hFFFF_FFFF, 0, 40, 54, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 8, CompRgb, 2, 2, 257, 40, 2000, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 8, CompRgb, 2, 2, 4, 30, 80, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 8, CompRgb, 2, 2, 4, 40, 69, PAL_RANDOM, 1'b1, 60);
    send_file(SigBm, 1, 24, CompRgb, 2, 2, 0, 40, 53, PAL_RANDOM, 1'b1, 60);
    wait_drained();
  endtask

  task automatic test_palettes();
    send_file(SigBm, 1, 8, CompRgb, 3, 2, 0, 40, 1078, PAL_RAMP);
    send_file(SigBm, 1, 8, CompRgb, 2, 2, 256, 40, 1078, PAL_BROKEN_RAMP);
    send_file(SigBm, 1, 8, CompBitfields, 5, 3, 4, 44, 80, PAL_RANDOM);
    send_file(SigBm, 1, 8, CompRgb, 1, 1, 1, 40, 58, PAL_RANDOM);
    wait_drained();
  endtask

  task automatic test_true_colour();
    send_file(SigBm, 1, 24, CompRgb, 1, 3, 0, 40, 54, PAL_RANDOM);
    send_file(SigBm, 1, 24, CompBitfields, 3, 2, 0, 40, 57, PAL_RANDOM);
    send_file(SigBm, 1, 32, CompBitfields, 3, 2, 0, 108, 66, PAL_RANDOM);
    send_file(SigBm, 1, 32, CompRgb, 2, 2, 0, 40, 54, PAL_RANDOM);
    wait_drained();
  endtask

  // largest accepted sizes; only the first pixel bytes are streamed (tall file's bottom row is y = 4095)
  task automatic test_size_extremes();
    src_idle_pct = 0; sink_idle_pct = 0;
    send_file(SigBm, 1, 8, CompRgb, MaxWidth, 1, 2, 40, 62, PAL_RANDOM, 1'b1, 160);
    send_file(SigBm, 1, 8, CompRgb, 1, MaxHeight, 2, 40, 62, PAL_RANDOM, 1'b1, 160);
    wait_drained();
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0; sink_idle_pct = 0;
    hold_left = 200;
    send_file(SigBm, 1, 24, CompRgb, 5, 4, 0, 40, 54, PAL_RANDOM);
    wait_drained();
  endtask

  task automatic test_random_files();
    int start_bytes = bytes_sent;
    int r, depth;
    logic [31:0] w, h, cols, isz, ofs;
    while (bytes_sent - start_bytes < 1250) begin
      src_idle_pct = ($urandom_range(3) == 0) ? 0 : 25;
      sink_idle_pct = ($urandom_range(3) == 0) ? 0 : 25;
      r = $urandom_range(99);
      depth = (r % 3 == 0) ? 8 : (r % 3 == 1) ? 24 : 32;
      w = $urandom_range(6, 1);
      h = $urandom_range(4, 1);
      cols = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
      isz = 40 + $urandom_range(6);
      ofs = (depth == 8) ? 14 + isz + 4 * (cols == 0 ? 256 : cols) + $urandom_range(5)
                         : 54 + $urandom_range(5);
      if (r < 85)
        send_file(SigBm, 1, depth, $urandom_range(1) ? CompRgb : CompBitfields,
                  w, h, cols, isz, ofs, PAL_RANDOM);
      else if (r < 95)
        send_file(SigBm, 1, depth, CompRgb, w, h, cols, isz, ofs, PAL_RANDOM, 1'b1, -1,
                  $urandom_range(2, 1));
      else
        send_file(SigBm, 1, depth, CompRgb, w, h, cols, isz, ofs, PAL_RANDOM, 1'b1,
                  $urandom_range(120, 10));
    end
    wait_drained();
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // one beat per cycle at most; values are stable by the falling edge
  always @(negedge clk) begin
    bmp_out_t e, a;
    if (!rst && out_if.valid && out_if.ready) begin
      a = out_if.data;
      if (expected_results.size() == 0) begin
        $error("unexpected output beat, kind %0d", a.kind);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, a.kind);
        check_field("error_code", e.error_code, a.error_code);
        check_field("pixel_x", e.pixel_x, a.pixel_x);
        check_field("pixel_y", e.pixel_y, a.pixel_y);
        check_field("red", e.red, a.red);
        check_field("green", e.green, a.green);
        check_field("blue", e.blue, a.blue);
        check_field("palette_index", e.palette_index, a.palette_index);
        check_field("format", e.format, a.format);
        check_field("last", e.last, a.last);
        beats_checked++;
        case (e.kind)
          KIND_PIXEL: n_pixels++;
          KIND_PALETTE: n_entries++;
          default: n_errors++;
        endcase
      end
    end
  end

  // output side: random stalls plus a counted hold-off when asked
  initial begin
    int gap_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_if.ready <= 1'b0;
        gap_left--;
      end else begin
        gap_left = pick_gap(sink_idle_pct);
        out_if.ready <= (gap_left == 0);
        if (gap_left > 0) gap_left--;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("bmp_stream_decoder_test NOT OK");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    hold_left = 0; src_idle_pct = 0; sink_idle_pct = 0;
    fail_count = 0; beats_checked = 0; bytes_sent = 0; files_sent = 0;
    n_pixels = 0; n_entries = 0; n_errors = 0;
    clear_decoder();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_header_errors();
    test_palettes();
    test_true_colour();
    test_size_extremes();
    test_output_stall();
    test_random_files();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected beats never arrived", expected_results.size());
      fail_count++;
    end
    $display("%0d files, %0d bytes: %0d pixels, %0d palette entries, %0d header errors",
             files_sent, bytes_sent, n_pixels, n_entries, n_errors);
    $display("%0d beats compared, %0d mismatches", beats_checked, fail_count);
    if (fail_count == 0) $display("bmp_stream_decoder_test OK");
    else $display("bmp_stream_decoder_test NOT OK");
    $finish;
  end
endmodule
